### rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int unsigned COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

endpackage

`default_nettype wire

### rtl/point_in_polygon_test.sv
// Point-in-polygon test by ray casting over a vertex memory.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | operation, x_coord, y_coord
//  out     | out_valid/out_ready| inside_res, vertex_count, dropped
//
// Clear and append beats load the output register when they are accepted.
// A query streams the stored vertices out of the memory at one read per cycle,
// through the registered read port and the four-stage edge pipeline, and
// loads its result once the pipeline has drained.
// Reset empties the polygon; vertex memory contents are not cleared.
// A new beat is taken when the block is idle and the output register is free
// or being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test #(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_WIDTH  = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [1:0]                             operation,
    input  wire logic signed [COORD_WIDTH-1:0]          x_coord,
    input  wire logic signed [COORD_WIDTH-1:0]          y_coord,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        inside_res,
    output logic [pip_pkg::COUNT_OUT_W-1:0]             vertex_count,
    output logic                                        dropped
);

    localparam int unsigned AW   = $clog2(MAX_VERTICES);
    localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned VW   = 2 * CW;
    localparam int unsigned DW   = CW + 1;
    localparam int unsigned PW   = 2 * DW;

    pip_pkg::state_t state_reg, state_next;

    logic [CNTW-1:0]        count_reg, count_next;
    logic [CNTW-1:0]        rd_next_reg, rd_next_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   have_prev_reg, have_prev_next;
    logic signed [CW-1:0]   qx_reg, qy_reg;
    logic [VW-1:0]          first_reg, prev_reg;

    logic [VW-1:0]          mem [MAX_VERTICES];
    logic [VW-1:0]          rdata_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   out_inside;
    logic                   out_dropped;
    logic                   parity_clr;
    logic                   cap_first;
    logic                   cap_prev;
    logic                   emit;
    logic [VW-1:0]          emit_a, emit_b;
    logic                   full;

    logic                   out_valid_reg;
    logic                   inside_reg, dropped_reg;
    logic [CNTW-1:0]        out_count_reg;

    logic                   e_vld_reg;
    logic signed [CW-1:0]   e_xa_reg, e_ya_reg, e_xb_reg, e_yb_reg;
    logic signed [CW-1:0]   a_x, a_y, b_x, b_y;

    logic                   s2_vld_reg, s2_cand_reg, s2_vert_reg;
    logic signed [DW-1:0]   s2_dx_reg, s2_dy_reg, s2_ey_reg, s2_ex_reg;
    logic                   s2_cand_next;
    logic signed [CW-1:0]   e_xmax;

    logic                   s3_vld_reg, s3_cand_reg, s3_vert_reg;
    logic signed [PW-1:0]   s3_p1_reg, s3_p2_reg;
    logic                   parity_reg;

    assign full     = (count_reg == CNTW'(MAX_VERTICES));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == pip_pkg::S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_next_next   = rd_next_reg;
        rd_pend_next   = rd_pend_reg;
        have_prev_next = have_prev_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_next_reg[AW-1:0];
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_inside     = 1'b0;
        out_dropped    = 1'b0;
        parity_clr     = 1'b0;
        cap_first      = 1'b0;
        cap_prev       = 1'b0;
        emit           = 1'b0;
        emit_a         = prev_reg;
        emit_b         = rdata_reg;
        unique case (state_reg)
            pip_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        pip_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            out_load   = 1'b1;
                        end
                        pip_pkg::OP_APPEND:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                out_dropped = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        pip_pkg::OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                rd_next_next   = CNTW'(1);
                                rd_pend_next   = 1'b1;
                                have_prev_next = 1'b0;
                                parity_clr     = 1'b1;
                                state_next     = pip_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            pip_pkg::S_SCAN:
            begin
                rd_pend_next = 1'b0;
                if (rd_next_reg != count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_next_next = rd_next_reg + CNTW'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    cap_prev = 1'b1;
                    if (!have_prev_reg)
                    begin
                        cap_first      = 1'b1;
                        have_prev_next = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    // Closing edge from the last vertex back to the first.
                    emit       = 1'b1;
                    emit_b     = first_reg;
                    state_next = pip_pkg::S_DRAIN;
                end
            end
            pip_pkg::S_DRAIN:
            begin
                if (!(e_vld_reg || s2_vld_reg || s3_vld_reg) && out_free)
                begin
                    out_load   = 1'b1;
                    out_inside = parity_reg;
                    state_next = pip_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pip_pkg::S_IDLE;
            count_reg     <= '0;
            rd_next_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            e_vld_reg     <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_next_reg   <= rd_next_next;
            rd_pend_reg   <= rd_pend_next;
            have_prev_reg <= have_prev_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            e_vld_reg  <= emit;
            s2_vld_reg <= e_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (parity_clr)
            begin
                parity_reg <= 1'b0;
            end
            else if (s3_vld_reg && s3_cand_reg && (s3_vert_reg || (s3_p1_reg <= s3_p2_reg)))
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    // Vertex memory: one write port for appends, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= {x_coord, y_coord};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (operation == pip_pkg::OP_QUERY))
        begin
            qx_reg <= x_coord;
            qy_reg <= y_coord;
        end
        if (cap_first)
        begin
            first_reg <= rdata_reg;
        end
        if (cap_prev)
        begin
            prev_reg <= rdata_reg;
        end
        if (out_load)
        begin
            inside_reg    <= out_inside;
            dropped_reg   <= out_dropped;
            out_count_reg <= count_next;
        end
    end

    // Edge stage: order the endpoints so that ya <= yb.
    assign a_x = emit_a[VW-1:CW];
    assign a_y = emit_a[CW-1:0];
    assign b_x = emit_b[VW-1:CW];
    assign b_y = emit_b[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (a_y > b_y)
            begin
                e_xa_reg <= b_x;
                e_ya_reg <= b_y;
                e_xb_reg <= a_x;
                e_yb_reg <= a_y;
            end
            else
            begin
                e_xa_reg <= a_x;
                e_ya_reg <= a_y;
                e_xb_reg <= b_x;
                e_yb_reg <= b_y;
            end
        end
    end

    // Range checks and differences for the cross-multiplied crossing test.
    assign e_xmax       = (e_xa_reg > e_xb_reg) ? e_xa_reg : e_xb_reg;
    assign s2_cand_next = (e_ya_reg != e_yb_reg) && (qy_reg > e_ya_reg)
                          && (qy_reg <= e_yb_reg) && (qx_reg <= e_xmax);

    always_ff @(posedge clk)
    begin
        if (e_vld_reg)
        begin
            s2_cand_reg <= s2_cand_next;
            s2_vert_reg <= (e_xa_reg == e_xb_reg);
            s2_dx_reg   <= DW'(qx_reg) - DW'(e_xa_reg);
            s2_dy_reg   <= DW'(e_yb_reg) - DW'(e_ya_reg);
            s2_ey_reg   <= DW'(qy_reg) - DW'(e_ya_reg);
            s2_ex_reg   <= DW'(e_xb_reg) - DW'(e_xa_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            s3_cand_reg <= s2_cand_reg;
            s3_vert_reg <= s2_vert_reg;
            s3_p1_reg   <= PW'(s2_dx_reg) * PW'(s2_dy_reg);
            s3_p2_reg   <= PW'(s2_ey_reg) * PW'(s2_ex_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign dropped    = dropped_reg;

    generate
        if (CNTW >= pip_pkg::COUNT_OUT_W)
        begin : g_count_trunc
            assign vertex_count = out_count_reg[pip_pkg::COUNT_OUT_W-1:0];
        end
        else
        begin : g_count_ext
            assign vertex_count = pip_pkg::COUNT_OUT_W'(out_count_reg);
        end
    endgenerate

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_VERTICES))
        else $error("Vertex count exceeds the store depth.");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (state_reg == pip_pkg::S_SCAN)) |-> (rd_next_reg < count_reg))
        else $error("Scan read beyond the stored vertices.");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> full)
        else $error("Dropped flag set while the store has room.");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pip_pkg::S_IDLE) |-> !(e_vld_reg || s2_vld_reg || s3_vld_reg))
        else $error("Edge pipeline busy while idle.");

    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pip_pkg::S_DRAIN) && (state_next == pip_pkg::S_IDLE))
        |=> (out_valid_reg && !dropped_reg))
        else $error("Query finished without loading its result.");

endmodule

`default_nettype wire

### verif/pip_result_checker.sv
// Checker for the point-in-polygon block: tracks the polygon, predicts each answer and compares.
`timescale 1ns / 1ps

module pip_result_checker
    import pip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic signed [15:0]       x_coord,
    input  logic signed [15:0]       y_coord,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     inside_res,
    input  logic [COUNT_OUT_W-1:0]   vertex_count,
    input  logic                     dropped,
    output int                       fail_count,
    output int                       pending,
    output int                       checked_count,
    output int                       inside_seen,
    output int                       refused_seen
);

    localparam int POLY_DEPTH = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   in_poly;
        logic [COUNT_OUT_W-1:0] count;
        logic                   refused;
    } answer_t;

    answer_t            answers_due[$];
    logic signed [15:0] poly_x [POLY_DEPTH];
    logic signed [15:0] poly_y [POLY_DEPTH];
    int                 poly_len = 0;
    int                 failures = 0;
    int                 checked = 0;
    int                 insides = 0;
    int                 refusals = 0;

    // Crossing-number parity of a ray cast from the point toward +x.
    function automatic logic ray_crossing_odd(input logic signed [15:0] px,
                                              input logic signed [15:0] py);
        longint qx;
        longint qy;
        longint xa;
        longint ya;
        longint xb;
        longint yb;
        longint t;
        int     j;
        logic   odd;
        qx  = px;
        qy  = py;
        odd = 1'b0;
        for (int i = 0; i < poly_len; i++)
        begin
            j  = (i + 1 >= poly_len) ? 0 : i + 1;
            xa = poly_x[i];
            ya = poly_y[i];
            xb = poly_x[j];
            yb = poly_y[j];
            if (ya == yb)
                continue;
            if (ya > yb)
            begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            if (!(qy > ya && qy <= yb))
                continue;
            if (qx > ((xa > xb) ? xa : xb))
                continue;
            if (xa == xb || (qx - xa) * (yb - ya) <= (qy - ya) * (xb - xa))
                odd = !odd;
        end
        return odd;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        answer_t next;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: unexpected result inside=%0d count=%0d dropped=%0d",
                                 $time, inside_res, vertex_count, dropped);
                end
                else
                begin
                    want = answers_due.pop_front();
                    checked++;
                    if (inside_res === 1'b1)
                        insides++;
                    if (dropped === 1'b1)
                        refusals++;
                    if (want.in_poly !== inside_res || want.count !== vertex_count ||
                        want.refused !== dropped)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch expected inside=%0d count=%0d dropped=%0d",
                                     $time, want.in_poly, want.count, want.refused);
                            $display("    got inside=%0d count=%0d dropped=%0d",
                                     inside_res, vertex_count, dropped);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                next.in_poly = 1'b0;
                next.refused = 1'b0;
                case (operation)
                    OP_CLEAR:
                        poly_len = 0;
                    OP_APPEND:
                        if (poly_len < POLY_DEPTH)
                        begin
                            poly_x[poly_len] = x_coord;
                            poly_y[poly_len] = y_coord;
                            poly_len++;
                        end
                        else
                            next.refused = 1'b1;
                    OP_QUERY:
                        next.in_poly = ray_crossing_odd(x_coord, y_coord);
                    default:
                        ;
                endcase
                next.count = COUNT_OUT_W'(poly_len);
                answers_due = {answers_due, next};
            end
        end
        pending       <= answers_due.size();
        fail_count    <= failures;
        checked_count <= checked;
        inside_seen   <= insides;
        refused_seen  <= refusals;
    end

endmodule

### verif/tb_point_in_polygon_test.sv
// Testbench top for the point-in-polygon block: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_point_in_polygon_test;

    import pip_pkg::*;

    localparam int          RESET_CYCLES = 7;
    localparam int          ITEMS        = 1200;
    localparam int          TAIL_ITEMS   = 150;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          SHAPE_DEPTH  = 64;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             operation = OP_CLEAR;
    logic signed [15:0]     x_coord = '0;
    logic signed [15:0]     y_coord = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   inside_res;
    logic [COUNT_OUT_W-1:0] vertex_count;
    logic                   dropped;

    int                     fail_count;
    int                     pending;
    int                     checked_count;
    int                     inside_seen;
    int                     refused_seen;

    int                     beats_sent = 0;
    int                     gap_odds = 0;
    bit                     quiet_tail = 1'b0;
    bit                     held = 1'b0;
    int                     stall_cycles = 0;
    logic signed [15:0]     shape_x [SHAPE_DEPTH];
    logic signed [15:0]     shape_y [SHAPE_DEPTH];
    int                     shape_n = 0;

    always #5 clk = ~clk;

    point_in_polygon_test u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_res   (inside_res),
        .vertex_count (vertex_count),
        .dropped      (dropped)
    );

    pip_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .inside_res    (inside_res),
        .vertex_count  (vertex_count),
        .dropped       (dropped),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .inside_seen   (inside_seen),
        .refused_seen  (refused_seen)
    );

    function automatic int pick_coord(input int spread);
        if (spread == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Offers one beat and returns once it is taken; valid stays high afterwards.
    task automatic send_beat(input logic [1:0] op, input int x, input int y);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        x_coord   <= 16'(x);
        y_coord   <= 16'(y);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (op == OP_CLEAR)
            shape_n = 0;
        else if (op == OP_APPEND && shape_n < SHAPE_DEPTH)
        begin
            shape_x[shape_n] = 16'(x);
            shape_y[shape_n] = 16'(y);
            shape_n++;
        end
    endtask

    task automatic ask_point(input int spread);
        int k;
        int v;
        k = $urandom_range(0, 3);
        v = (shape_n > 0) ? $urandom_range(0, shape_n - 1) : 0;
        if (shape_n > 0 && k == 0)
            send_beat(OP_QUERY, shape_x[v], shape_y[v]);
        else if (shape_n > 0 && k == 1)
            send_beat(OP_QUERY, pick_coord(spread), shape_y[v]);
        else
            send_beat(OP_QUERY, pick_coord(spread), pick_coord(spread));
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            if (!held && beats_sent >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles.", STALL_LIMIT);
                $display("tb_point_in_polygon_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int spread;
        int corners;
        int asks;
        int pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds = 3;
        send_beat(OP_QUERY, 0, 0);
        send_beat(OP_UNUSED, 0, 0);
        send_beat(OP_APPEND, -32768, -32768);
        send_beat(OP_APPEND, 32767, -32768);
        send_beat(OP_APPEND, 32767, 32767);
        send_beat(OP_APPEND, -32768, 32767);
        send_beat(OP_QUERY, 0, 0);
        send_beat(OP_QUERY, -32768, -32768);
        send_beat(OP_QUERY, 32767, 0);
        send_beat(OP_QUERY, -32768, 0);
        send_beat(OP_QUERY, 0, 32767);
        send_beat(OP_QUERY, 0, -32768);
        send_beat(OP_QUERY, -1, -1);
        send_beat(OP_UNUSED, -1, 32767);
        send_beat(OP_CLEAR, -1, -1);
        send_beat(OP_APPEND, 0, 0);
        send_beat(OP_QUERY, 0, 0);
        send_beat(OP_APPEND, 10, 0);
        send_beat(OP_QUERY, 5, 0);
        send_beat(OP_APPEND, 5, 10);
        send_beat(OP_QUERY, 5, 5);
        send_beat(OP_QUERY, 5, 10);
        send_beat(OP_QUERY, 10, 5);
        send_beat(OP_QUERY, -32768, 5);
        send_beat(OP_QUERY, 2, 0);

        while (beats_sent < ITEMS)
        begin
            quiet_tail = (beats_sent >= ITEMS - TAIL_ITEMS);
            if (quiet_tail || $urandom_range(0, 2) == 0)
                gap_odds = 0;
            else
                gap_odds = $urandom_range(2, 8);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    3:       spread = 2000;
                    default: spread = 24;
                endcase
                if (pick == 1)
                    corners = $urandom_range(60, 70);
                else if (pick == 2)
                    corners = $urandom_range(0, 2);
                else
                    corners = $urandom_range(3, 10);
                asks = $urandom_range(2, 12);
                if ($urandom_range(0, 5) != 0)
                    send_beat(OP_CLEAR, pick_coord(0), pick_coord(0));
                repeat (corners)
                    send_beat(OP_APPEND, pick_coord(spread), pick_coord(spread));
                repeat (asks)
                    ask_point(spread);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d beats and %0d checked answers, with clears, appends,",
                 beats_sent, checked_count);
        $display("queries and unused codes; %0d answers inside, %0d appends refused when full.",
                 inside_seen, refused_seen);
        if (fail_count == 0)
            $display("tb_point_in_polygon_test: PASS");
        else
            $display("tb_point_in_polygon_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/pip_pkg.sv
rtl/point_in_polygon_test.sv
verif/pip_result_checker.sv
verif/tb_point_in_polygon_test.sv
